@@ hw/rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk, off during rst.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ hw/rtl/upc_pkg.sv @@
package upc_pkg;

  localparam int CMD_SLOTS   = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_DIRECTION = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_COMPONENT = 1'b1;

  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  localparam logic [2:0] COMP_NONE     = 3'd0;
  localparam logic [2:0] COMP_USERINFO = 3'd1;
  localparam logic [2:0] COMP_HOST     = 3'd2;
  localparam logic [2:0] COMP_PATH     = 3'd3;
  localparam logic [2:0] COMP_QUERY    = 3'd4;
  localparam logic [2:0] COMP_FRAGMENT = 3'd5;

  localparam logic [7:0] CHAR_PERCENT = 8'h25;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_item_t;

  typedef struct packed {
    logic [CMD_SLOTS-1:0][7:0] bytes;
    logic [1:0]                count;
    logic                      last;
  } cmd_t;

  function automatic logic passes(input logic [7:0] b, input logic [2:0] comp);
    logic hit;
    hit = (b inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39]}) ||
          (b inside {8'h21, 8'h27, 8'h28, 8'h29, 8'h2A, 8'h2D, 8'h2E, 8'h5F, 8'h7E});
    case (comp)
      COMP_USERINFO: hit = hit || (b == 8'h3A);
      COMP_HOST:     hit = hit || (b inside {8'h5B, 8'h3A, 8'h5D});
      COMP_PATH:     hit = hit || (b inside {8'h2F, 8'h2E, 8'h40, 8'h25, 8'h3B, 8'h3D});
      COMP_QUERY:    hit = hit || (b inside {8'h2F, 8'h3F});
      COMP_FRAGMENT: hit = hit ||
                           (b inside {8'h2F, 8'h2E, 8'h40, 8'h26, 8'h6C, 8'h3B, 8'h3D, 8'h25});
      default:       hit = hit;
    endcase
    return hit;
  endfunction

  function automatic logic is_hex(input logic [7:0] b);
    return b inside {[8'h30:8'h39], [8'h41:8'h46]};
  endfunction

  function automatic logic [3:0] hex_value(input logic [7:0] b);
    logic [7:0] v;
    if (b inside {[8'h30:8'h39]}) v = b - 8'h30;
    else if (b inside {[8'h41:8'h46]}) v = b - 8'h37;
    else v = 8'h00;
    return v[3:0];
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) c = 8'h30 + {4'h0, nib};
    else c = 8'h37 + {4'h0, nib};
    return c;
  endfunction

endpackage

@@ hw/rtl/upc_front.sv @@
module upc_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             accept,
  input  upc_pkg::in_item_t                item,
  input  logic                             wr_en,
  input  logic [upc_pkg::CFG_INDEX_W-1:0]  wr_index,
  input  logic [upc_pkg::CFG_DATA_W-1:0]   wr_data,
  output logic                             cmd_push,
  output upc_pkg::cmd_t                    cmd
);

  typedef enum logic [1:0] {PH_IDLE, PH_PCT, PH_DIGIT} phase_t;

  phase_t     phase;
  phase_t     phase_next;
  logic       direction;
  logic [2:0] component;
  logic [7:0] held_digit;
  logic [7:0] held_digit_next;

  always_comb begin
    logic [7:0] b;
    logic [1:0] n;
    logic       hv;
    b               = item.in_byte;
    hv              = upc_pkg::is_hex(b);
    n               = 2'd0;
    cmd             = '0;
    phase_next      = phase;
    held_digit_next = held_digit;
    if (direction == upc_pkg::DIR_ENCODE) begin
      if (upc_pkg::passes(b, component)) begin
        cmd.bytes[0] = b;
        n = 2'd1;
      end else begin
        cmd.bytes[0] = upc_pkg::CHAR_PERCENT;
        cmd.bytes[1] = upc_pkg::hex_char(b[7:4]);
        cmd.bytes[2] = upc_pkg::hex_char(b[3:0]);
        n = 2'd3;
      end
    end else begin
      case (phase)
        PH_PCT: begin
          if (hv) begin
            held_digit_next = b;
            phase_next = PH_DIGIT;
          end else if (b == upc_pkg::CHAR_PERCENT) begin
            cmd.bytes[0] = upc_pkg::CHAR_PERCENT;
            n = 2'd1;
          end else begin
            cmd.bytes[0] = upc_pkg::CHAR_PERCENT;
            cmd.bytes[1] = b;
            n = 2'd2;
            phase_next = PH_IDLE;
          end
        end
        PH_DIGIT: begin
          if (hv) begin
            cmd.bytes[0] = {upc_pkg::hex_value(held_digit), upc_pkg::hex_value(b)};
            n = 2'd1;
            phase_next = PH_IDLE;
          end else if (b == upc_pkg::CHAR_PERCENT) begin
            cmd.bytes[0] = upc_pkg::CHAR_PERCENT;
            cmd.bytes[1] = held_digit;
            n = 2'd2;
            phase_next = PH_PCT;
          end else begin
            cmd.bytes[0] = upc_pkg::CHAR_PERCENT;
            cmd.bytes[1] = held_digit;
            cmd.bytes[2] = b;
            n = 2'd3;
            phase_next = PH_IDLE;
          end
        end
        default: begin
          if (b == upc_pkg::CHAR_PERCENT) begin
            phase_next = PH_PCT;
          end else begin
            cmd.bytes[0] = b;
            n = 2'd1;
            phase_next = PH_IDLE;
          end
        end
      endcase
      // flush what is still held on the last byte
      if (item.in_last) begin
        if (phase_next == PH_PCT) begin
          cmd.bytes[n] = upc_pkg::CHAR_PERCENT;
          n = n + 2'd1;
        end else if (phase_next == PH_DIGIT) begin
          cmd.bytes[n] = upc_pkg::CHAR_PERCENT;
          n = n + 2'd1;
          cmd.bytes[n] = held_digit_next;
          n = n + 2'd1;
        end
        phase_next = PH_IDLE;
      end
      if (phase_next != PH_DIGIT) held_digit_next = 8'h00;
    end
    cmd.count = n;
    cmd.last  = item.in_last;
    cmd_push  = accept && (n != 2'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      held_digit <= 8'h00;
      direction  <= upc_pkg::DIR_ENCODE;
      component  <= upc_pkg::COMP_NONE;
    end else begin
      if (accept && direction == upc_pkg::DIR_DECODE) begin
        phase      <= phase_next;
        held_digit <= held_digit_next;
      end
      if (wr_en) begin
        case (wr_index)
          upc_pkg::REG_DIRECTION: begin
            direction  <= wr_data[0];
            phase      <= PH_IDLE;
            held_digit <= 8'h00;
          end
          upc_pkg::REG_COMPONENT: begin
            component <= wr_data[2:0];
          end
          default: begin
            component <= component;
          end
        endcase
      end
    end
  end

endmodule

@@ hw/rtl/upc_queue.sv @@
module upc_queue #(
  parameter int DEPTH = upc_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  upc_pkg::cmd_t wdata,
  output logic          full,
  input  logic          pop,
  output upc_pkg::cmd_t head,
  output logic          head_valid
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  upc_pkg::cmd_t    mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full       = (count == CNT_FULL);
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PTR_MAX) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == PTR_MAX) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

endmodule

@@ hw/rtl/upc_back.sv @@
module upc_back (
  input  logic               clk,
  input  logic               rst,
  input  upc_pkg::cmd_t      head,
  input  logic               head_valid,
  output logic               head_pop,
  output upc_pkg::out_item_t result,
  output logic               empty,
  input  logic               pop
);

  logic [1:0] idx;
  logic       out_valid;
  logic       load;
  logic       final_slot;

  assign empty      = !out_valid;
  assign load       = head_valid && (!out_valid || pop);
  assign final_slot = (idx == head.count - 2'd1);
  assign head_pop   = load && final_slot;

  always_ff @(posedge clk) begin
    if (load) begin
      result.out_byte <= head.bytes[idx];
      result.out_last <= head.last && final_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= final_slot ? 2'd0 : idx + 2'd1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ hw/rtl/uri_percent_codec_unit.sv @@
// channel   dir  handshake       payload
// item      in   push / full     in_byte, in_last
// result    out  pop / empty     out_byte, out_last
// config    in   wr_en           wr_index, wr_data
//
// The front takes one byte per cycle unless full; the back sends one per cycle if pop is high.
// An escaped byte gives three bytes, a plain byte one; the single result port sets the rate.
// A command queue of QUEUE_DEPTH entries sits between front and back; full follows it.
// Result stays on the ports while pop is low. Reset clears config, decode state and queue.
module uri_percent_codec_unit #(
  parameter int QUEUE_DEPTH = upc_pkg::QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  upc_pkg::in_item_t               item,
  output logic                            empty,
  input  logic                            pop,
  output upc_pkg::out_item_t              result,
  input  logic                            wr_en,
  input  logic [upc_pkg::CFG_INDEX_W-1:0] wr_index,
  input  logic [upc_pkg::CFG_DATA_W-1:0]  wr_data
);

  logic          accept;
  logic          cmd_push;
  upc_pkg::cmd_t cmd;
  upc_pkg::cmd_t head;
  logic          head_valid;
  logic          head_pop;

  assign accept = push && !full;

  upc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .item     (item),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cmd_push (cmd_push),
    .cmd      (cmd)
  );

  upc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (cmd_push),
    .wdata      (cmd),
    .full       (full),
    .pop        (head_pop),
    .head       (head),
    .head_valid (head_valid)
  );

  upc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .head_pop   (head_pop),
    .result     (result),
    .empty      (empty),
    .pop        (pop)
  );

endmodule

@@ hw/rtl/upc_checker.sv @@
`include "assert_macros.svh"

module upc_checker (
  input logic               clk,
  input logic               rst,
  input logic               push,
  input logic               full,
  input upc_pkg::in_item_t  item,
  input logic               empty,
  input logic               pop,
  input upc_pkg::out_item_t result
);

  `ASSERT_NEXT(a_result_hold, !empty && !pop, !empty && $stable(result))
  `ASSERT_IMPL(a_reset_clear, $past(rst), empty && !full)
  `ASSERT_IMPL(a_last_yields, push && !full && item.in_last, ##2 !empty)

endmodule

bind uri_percent_codec_unit upc_checker u_upc_checker (.*);

@@ tb/uri_percent_codec_unit_test.sv @@
module uri_percent_codec_unit_test;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 200;
  localparam int REPORT_LIMIT  = 10;
  localparam int RANDOM_ITEMS  = 48;

  localparam logic [2:0] COMP_SPARE_6 = 3'd6;
  localparam logic [2:0] COMP_SPARE_7 = 3'd7;

  typedef enum logic [1:0] {ESC_IDLE, ESC_PERCENT, ESC_DIGIT, ESC_UNUSED} esc_phase_t;
  typedef enum int {PACE_STEADY, PACE_SENDER_IDLE, PACE_RECEIVER_STALL, PACE_BOTH} pace_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            push = 1'b0;
  logic                            full;
  upc_pkg::in_item_t               item = '0;
  logic                            empty;
  logic                            pop = 1'b0;
  upc_pkg::out_item_t              result;
  logic                            wr_en = 1'b0;
  logic [upc_pkg::CFG_INDEX_W-1:0] wr_index = '0;
  logic [upc_pkg::CFG_DATA_W-1:0]  wr_data = '0;

  logic       codec_dir = upc_pkg::DIR_ENCODE;
  logic [2:0] codec_comp = upc_pkg::COMP_NONE;
  esc_phase_t esc_phase = ESC_IDLE;
  logic [7:0] esc_digit = 8'h00;

  upc_pkg::out_item_t expected_out[$];
  upc_pkg::out_item_t want_item;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_token = 0;
  int seen_token = 0;
  int hold_left = 0;
  int cycles = 0;
  int items_sent = 0;
  int results_seen = 0;
  int failures = 0;
  int bytes_escaped = 0;
  int bytes_decoded = 0;
  int full_stalls = 0;

  uri_percent_codec_unit dut (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .item     (item),
    .empty    (empty),
    .pop      (pop),
    .result   (result),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic bit in_chars(input logic [7:0] b, input string s);
    for (int i = 0; i < s.len(); i++) begin
      if (s[i] == b) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit stays_plain(input logic [7:0] b, input logic [2:0] comp);
    if ((b >= "A" && b <= "Z") || (b >= "a" && b <= "z") || (b >= "0" && b <= "9")) return 1'b1;
    if (in_chars(b, "!'()*-._~")) return 1'b1;
    case (comp)
      upc_pkg::COMP_USERINFO: return in_chars(b, ":");
      upc_pkg::COMP_HOST:     return in_chars(b, "[:]");
      upc_pkg::COMP_PATH:     return in_chars(b, "/.@%;=");
      upc_pkg::COMP_QUERY:    return in_chars(b, "/?");
      upc_pkg::COMP_FRAGMENT: return in_chars(b, "/.@&l;=%");
      default:                return 1'b0;
    endcase
  endfunction

  function automatic int digit_value(input logic [7:0] b);
    if (b >= "0" && b <= "9") return int'(b) - int'("0");
    if (b >= "A" && b <= "F") return int'(b) - int'("A") + 10;
    return -1;
  endfunction

  function automatic logic [7:0] upper_hex(input logic [3:0] nib);
    if (nib < 4'd10) return 8'("0") + 8'(nib);
    return 8'("A") + 8'(nib) - 8'd10;
  endfunction

  function automatic void emit(input logic [7:0] b);
    expected_out.push_back('{out_byte: b, out_last: 1'b0});
  endfunction

  task automatic predict_item(input upc_pkg::in_item_t it);
    int         base;
    int         hv;
    int         hi;
    esc_phase_t ph;
    logic [7:0] b;
    base = expected_out.size();
    b = it.in_byte;
    if (codec_dir == upc_pkg::DIR_ENCODE) begin
      if (stays_plain(b, codec_comp)) begin
        emit(b);
      end else begin
        emit(upc_pkg::CHAR_PERCENT);
        emit(upper_hex(b[7:4]));
        emit(upper_hex(b[3:0]));
        bytes_escaped++;
      end
    end else begin
      hv = digit_value(b);
      ph = (esc_phase == ESC_UNUSED) ? ESC_IDLE : esc_phase;
      case (ph)
        ESC_IDLE: begin
          if (b == upc_pkg::CHAR_PERCENT) ph = ESC_PERCENT;
          else emit(b);
        end
        ESC_PERCENT: begin
          if (hv >= 0) begin
            esc_digit = b;
            ph = ESC_DIGIT;
          end else if (b == upc_pkg::CHAR_PERCENT) begin
            emit(upc_pkg::CHAR_PERCENT);
          end else begin
            emit(upc_pkg::CHAR_PERCENT);
            emit(b);
            ph = ESC_IDLE;
          end
        end
        default: begin
          if (hv >= 0) begin
            hi = digit_value(esc_digit);
            if (hi < 0) hi = 0;
            emit({hi[3:0], hv[3:0]});
            bytes_decoded++;
            ph = ESC_IDLE;
          end else if (b == upc_pkg::CHAR_PERCENT) begin
            emit(upc_pkg::CHAR_PERCENT);
            emit(esc_digit);
            ph = ESC_PERCENT;
          end else begin
            emit(upc_pkg::CHAR_PERCENT);
            emit(esc_digit);
            emit(b);
            ph = ESC_IDLE;
          end
        end
      endcase
      if (it.in_last) begin
        if (ph == ESC_PERCENT) begin
          emit(upc_pkg::CHAR_PERCENT);
        end else if (ph == ESC_DIGIT) begin
          emit(upc_pkg::CHAR_PERCENT);
          emit(esc_digit);
        end
        ph = ESC_IDLE;
      end
      if (ph != ESC_DIGIT) esc_digit = 8'h00;
      esc_phase = ph;
    end
    if (it.in_last && expected_out.size() > base)
      expected_out[expected_out.size() - 1].out_last = 1'b1;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic lst);
    upc_pkg::in_item_t it;
    it = '{in_byte: b, in_last: lst};
    if ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    push <= 1'b1;
    item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_item(it);
    items_sent++;
  endtask

  task automatic send_text(input string s, input logic lst);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], lst && (i == s.len() - 1));
  endtask

  task automatic wait_drained;
    while (expected_out.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [upc_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [upc_pkg::CFG_DATA_W-1:0] val);
    push <= 1'b0;
    wait_drained();
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(posedge clk);
    wr_en <= 1'b0;
    if (idx == upc_pkg::REG_DIRECTION) begin
      codec_dir = val[0];
      esc_phase = ESC_IDLE;
      esc_digit = 8'h00;
    end else begin
      codec_comp = val;
    end
  endtask

  task automatic set_pacing(input pace_t pace);
    case (pace)
      PACE_SENDER_IDLE:    begin send_idle_pct = 58; recv_stall_pct = 0;  end
      PACE_RECEIVER_STALL: begin send_idle_pct = 0;  recv_stall_pct = 58; end
      PACE_BOTH:           begin send_idle_pct = 28; recv_stall_pct = 28; end
      default:             begin send_idle_pct = 0;  recv_stall_pct = 0;  end
    endcase
  endtask

  task automatic send_encode_byte;
    string      pool;
    logic [7:0] b;
    pool = ":[]/.@%;=?&l!'()*-_~ #";
    if ($urandom_range(99) < 70) b = 8'($urandom_range(255));
    else b = pool[$urandom_range(pool.len() - 1)];
    send_byte(b, $urandom_range(7) == 0);
  endtask

  task automatic send_decode_sequence;
    int         r;
    logic [7:0] v;
    logic       lst;
    r = $urandom_range(99);
    v = 8'($urandom_range(255));
    lst = ($urandom_range(9) == 0);
    if (r < 55) begin
      send_byte(upc_pkg::CHAR_PERCENT, 1'b0);
      send_byte(upper_hex(v[7:4]), 1'b0);
      send_byte(upper_hex(v[3:0]), lst);
    end else if (r < 65) begin
      send_byte(upc_pkg::CHAR_PERCENT, 1'b0);
      send_byte(upper_hex(v[7:4]), 1'b0);
      send_byte(8'($urandom_range(255)), lst);
    end else if (r < 72) begin
      send_byte(upc_pkg::CHAR_PERCENT, 1'b0);
      send_byte(8'("a") + 8'($urandom_range(5)), lst);
    end else if (r < 78) begin
      send_byte(upc_pkg::CHAR_PERCENT, 1'b0);
      send_byte(upc_pkg::CHAR_PERCENT, 1'b0);
      send_byte(upper_hex(v[7:4]), 1'b0);
      send_byte(upper_hex(v[3:0]), lst);
    end else if (r < 85) begin
      send_byte(upc_pkg::CHAR_PERCENT, 1'b0);
      send_byte(v, lst);
    end else begin
      send_byte(v, lst);
    end
  endtask

  task automatic test_encode_directed;
    set_pacing(PACE_STEADY);
    write_reg(upc_pkg::REG_DIRECTION, {2'b10, upc_pkg::DIR_ENCODE});
    write_reg(upc_pkg::REG_COMPONENT, upc_pkg::COMP_NONE);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_text("Az09~ %", 1'b0);
    send_byte(8'h0A, 1'b1);
    write_reg(upc_pkg::REG_COMPONENT, upc_pkg::COMP_PATH);
    send_text("/%?", 1'b1);
    write_reg(upc_pkg::REG_COMPONENT, upc_pkg::COMP_QUERY);
    send_text("?&", 1'b1);
    write_reg(upc_pkg::REG_COMPONENT, upc_pkg::COMP_FRAGMENT);
    send_text("&l%", 1'b1);
    write_reg(upc_pkg::REG_COMPONENT, upc_pkg::COMP_USERINFO);
    send_text(":[", 1'b1);
    write_reg(upc_pkg::REG_COMPONENT, upc_pkg::COMP_HOST);
    send_text("[]", 1'b1);
    write_reg(upc_pkg::REG_COMPONENT, COMP_SPARE_6);
    send_text(":/", 1'b1);
    write_reg(upc_pkg::REG_COMPONENT, COMP_SPARE_7);
    send_text("?", 1'b1);
  endtask

  task automatic test_decode_directed;
    set_pacing(PACE_STEADY);
    write_reg(upc_pkg::REG_DIRECTION, {2'b01, upc_pkg::DIR_DECODE});
    send_text("%41", 1'b0);
    send_text("%4a", 1'b0);
    send_text("%%2F", 1'b0);
    send_text("%2541", 1'b0);
    send_text("%FF", 1'b0);
    send_text("%", 1'b1);
    send_text("%C", 1'b1);
    send_text("x", 1'b1);
    // a direction write drops a held escape
    send_text("%", 1'b0);
    write_reg(upc_pkg::REG_DIRECTION, {2'b00, upc_pkg::DIR_DECODE});
    send_text("%4", 1'b0);
    write_reg(upc_pkg::REG_DIRECTION, {2'b11, upc_pkg::DIR_DECODE});
    send_text("41", 1'b1);
  endtask

  task automatic test_random_traffic(input pace_t pace, input int count);
    int         goal;
    logic [1:0] pad;
    logic       dir;
    set_pacing(pace);
    for (int chunk = 0; chunk < 3; chunk++) begin
      pad = 2'($urandom_range(3));
      dir = 1'($urandom_range(1));
      write_reg(upc_pkg::REG_DIRECTION, {pad, dir});
      write_reg(upc_pkg::REG_COMPONENT, 3'($urandom_range(7)));
      goal = items_sent + count / 3;
      while (items_sent < goal) begin
        if (codec_dir == upc_pkg::DIR_DECODE) send_decode_sequence();
        else send_encode_byte();
      end
    end
  endtask

  task automatic test_backpressure;
    set_pacing(PACE_STEADY);
    write_reg(upc_pkg::REG_DIRECTION, {2'b00, upc_pkg::DIR_ENCODE});
    write_reg(upc_pkg::REG_COMPONENT, upc_pkg::COMP_NONE);
    hold_token++;
    for (int i = 0; i < 40; i++) send_byte(8'(i), i == 39);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_token != seen_token) begin
      seen_token <= hold_token;
      hold_left <= HOLD_CYCLES;
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      results_seen++;
      if (expected_out.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("unexpected transfer: byte %h last %b", result.out_byte, result.out_last);
      end else begin
        want_item = expected_out.pop_front();
        if (result.out_byte !== want_item.out_byte || result.out_last !== want_item.out_last) begin
          failures++;
          if (failures <= REPORT_LIMIT)
            $display("transfer %0d: expected byte %h last %b, got byte %h last %b",
                     results_seen, want_item.out_byte, want_item.out_last,
                     result.out_byte, result.out_last);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && push && full) full_stalls++;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, expected_out.size());
      $display("uri_percent_codec_unit_test failed");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_encode_directed();
    test_decode_directed();
    test_random_traffic(PACE_STEADY, RANDOM_ITEMS);
    test_random_traffic(PACE_SENDER_IDLE, RANDOM_ITEMS);
    test_random_traffic(PACE_RECEIVER_STALL, RANDOM_ITEMS);
    test_random_traffic(PACE_BOTH, RANDOM_ITEMS);
    test_backpressure();
    push <= 1'b0;
    wait_drained();
    $display("%0d bytes in, %0d bytes out; %0d escaped on encode, %0d escapes decoded",
             items_sent, results_seen, bytes_escaped, bytes_decoded);
    $display("input held off by full for %0d cycles; %0d mismatches, %0d results left",
             full_stalls, failures, expected_out.size());
    if (failures == 0 && expected_out.size() == 0) begin
      $display("uri_percent_codec_unit_test passed");
    end else begin
      $display("uri_percent_codec_unit_test failed");
    end
    $finish;
  end

endmodule

@@ uri_percent_codec_unit.f @@
+incdir+hw/rtl
hw/rtl/upc_pkg.sv
hw/rtl/upc_front.sv
hw/rtl/upc_queue.sv
hw/rtl/upc_back.sv
hw/rtl/uri_percent_codec_unit.sv
hw/rtl/upc_checker.sv
tb/uri_percent_codec_unit_test.sv
